// ----- rtl/vectored_interrupt_controller_assert.svh -----
// Assertion macros shared by the interrupt controller RTL.
// Bodies are empty when SYNTHESIS is defined.
`ifndef VECTORED_INTERRUPT_CONTROLLER_ASSERT_SVH
`define VECTORED_INTERRUPT_CONTROLLER_ASSERT_SVH
`ifndef SYNTHESIS
// Check a property on the rising clock, held off while reset is asserted.
`define VIC_ASSERT(lbl, clk, rst_n, prop) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
		else $error("assertion failed");
// Check a property on the rising clock with no reset qualification.
`define VIC_ASSERT_NR(lbl, clk, prop) \
	lbl: assert property (@(posedge clk) prop) \
		else $error("assertion failed");
`else
`define VIC_ASSERT(lbl, clk, rst_n, prop)
`define VIC_ASSERT_NR(lbl, clk, prop)
`endif
`endif

// ----- rtl/vic_pkg.sv -----
// Types and constants for the vectored interrupt controller.
// No dependencies; imported by vic_core, vic_out_buf and the top level.
`timescale 1ns / 1ps
package vic_pkg;

	typedef enum logic [1:0] {
		MODE_READ  = 2'd0,
		MODE_WRITE = 2'd1,
		MODE_LEVEL = 2'd2,
		MODE_ACK   = 2'd3
	} mode_t;

	localparam logic [3:0] OFF_STATUS = 4'd1;
	localparam logic [3:0] OFF_BASE   = 4'd3;
	localparam logic [7:0] READ_IDLE  = 8'hff;

	typedef struct packed {
		logic [1:0] mode;
		logic [3:0] reg_offset;
		logic [7:0] write_value;
		logic [1:0] source_select;
		logic       source_level;
		logic       printer_ready;
	} item_t;

	typedef struct packed {
		logic [7:0] read_value;
		logic       irq_cancel;
		logic       irq_raise;
		logic [7:0] raise_vector;
		logic       request_pending;
	} result_t;

endpackage

// ----- rtl/vic_core.sv -----
// Register file, pending/enable state and vector selection for one transaction.
// Depends on vic_pkg and vectored_interrupt_controller_assert.svh.
`timescale 1ns / 1ps
`include "vectored_interrupt_controller_assert.svh"
module vic_core
	import vic_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	input  logic    accept,
	input  item_t   item,
	output result_t result
);

	logic [3:0] pend_q, pend_n;
	logic [3:0] en_q, en_n;
	logic [5:0] base_q, base_n;
	logic       held_valid_q, held_valid_n;
	logic [7:0] held_vec_q, held_vec_n;
	logic       eval;
	logic [3:0] active;
	logic [1:0] idx;
	logic [7:0] vec;

	always_comb begin
		pend_n       = pend_q;
		en_n         = en_q;
		base_n       = base_q;
		held_valid_n = held_valid_q;
		held_vec_n   = held_vec_q;
		eval         = 1'b0;
		result       = '0;
		result.read_value = READ_IDLE;

		case (mode_t'(item.mode))
			MODE_READ: begin
				if (item.reg_offset == OFF_STATUS) begin
					result.read_value = {pend_q[0], pend_q[1], item.printer_ready, pend_q[2],
						en_q[2], en_q[0], en_q[1], en_q[3]};
					// reading status clears the printer pending flag
					if (pend_q[3]) begin
						pend_n = {1'b0, pend_q[2:0]};
						eval   = 1'b1;
					end
				end
			end
			MODE_WRITE: begin
				if (item.reg_offset == OFF_STATUS) begin
					en_n = {item.write_value[0], item.write_value[3],
						item.write_value[1], item.write_value[2]};
					eval = 1'b1;
				end else if (item.reg_offset == OFF_BASE) begin
					base_n = item.write_value[7:2];
				end
			end
			MODE_LEVEL: begin
				pend_n[item.source_select] = item.source_level;
				eval = 1'b1;
			end
			default: begin
				held_valid_n = 1'b0;
			end
		endcase

		active = pend_n & en_n;
		if (active[0])      idx = 2'd0;
		else if (active[1]) idx = 2'd1;
		else if (active[2]) idx = 2'd2;
		else                idx = 2'd3;
		vec = {base_n, idx};

		if (eval) begin
			if (active == 4'd0) begin
				result.irq_cancel = held_valid_q;
				held_valid_n      = 1'b0;
			end else if (!(held_valid_q && held_vec_q == vec)) begin
				result.irq_cancel   = held_valid_q;
				result.irq_raise    = 1'b1;
				result.raise_vector = vec;
				held_valid_n        = 1'b1;
				held_vec_n          = vec;
			end
		end
		result.request_pending = held_valid_n;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q       <= '0;
			en_q         <= '0;
			base_q       <= '0;
			held_valid_q <= 1'b0;
			held_vec_q   <= '0;
		end else if (accept) begin
			pend_q       <= pend_n;
			en_q         <= en_n;
			base_q       <= base_n;
			held_valid_q <= held_valid_n;
			held_vec_q   <= held_vec_n;
		end
	end

	`VIC_ASSERT(a_ack_drops, clk, arst_n,
		accept && item.mode == MODE_ACK |=> !held_valid_q)
	`VIC_ASSERT(a_raise_holds, clk, arst_n,
		accept && result.irq_raise |=> held_valid_q && held_vec_q == $past(result.raise_vector))
	`VIC_ASSERT(a_cancel_needs_held, clk, arst_n,
		accept && result.irq_cancel |-> held_valid_q)
	`VIC_ASSERT_NR(a_ack_quiet, clk,
		item.mode == MODE_ACK |-> !result.irq_raise && !result.irq_cancel)

endmodule

// ----- rtl/vic_out_buf.sv -----
// Two-entry result queue that decouples the input and output handshakes.
// Depends on vic_pkg and vectored_interrupt_controller_assert.svh.
`timescale 1ns / 1ps
`include "vectored_interrupt_controller_assert.svh"
module vic_out_buf
	import vic_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	input  logic    push,
	input  result_t push_data,
	output logic    space,
	input  logic    pop_ready,
	output logic    pop_valid,
	output result_t pop_data
);

	result_t    mem_q [2];
	logic       wptr_q;
	logic       rptr_q;
	logic [1:0] count_q;
	logic       pop;

	assign space     = (count_q != 2'd2);
	assign pop_valid = (count_q != 2'd0);
	assign pop       = pop_valid && pop_ready;
	assign pop_data  = mem_q[rptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q  <= 1'b0;
			rptr_q  <= 1'b0;
			count_q <= 2'd0;
		end else begin
			if (push) wptr_q <= ~wptr_q;
			if (pop)  rptr_q <= ~rptr_q;
			case ({push, pop})
				2'b10:   count_q <= count_q + 2'd1;
				2'b01:   count_q <= count_q - 2'd1;
				default: count_q <= count_q;
			endcase
		end
	end

	`VIC_ASSERT(a_count_range, clk, arst_n, count_q != 2'd3)
	`VIC_ASSERT(a_no_overflow, clk, arst_n, push |-> space)
	`VIC_ASSERT(a_ptr_track, clk, arst_n,
		(wptr_q ^ rptr_q) == (count_q == 2'd1))

endmodule

// ----- rtl/vectored_interrupt_controller.sv -----
// Four-source vectored interrupt controller, top level.
// State and result are computed in one pass; each result is queued before output.
// Throughput: one transaction per cycle while the result queue has space.
// A two-entry result queue keeps input accepted while one result waits.
// Reset (arst_n low) clears pending, enables, vector base and the held vector.
`timescale 1ns / 1ps
module vectored_interrupt_controller
	import vic_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [1:0] mode,
	input  logic [3:0] reg_offset,
	input  logic [7:0] write_value,
	input  logic [1:0] source_select,
	input  logic       source_level,
	input  logic       printer_ready,
	output logic       out_valid,
	input  logic       out_ready,
	output logic [7:0] read_value,
	output logic       irq_cancel,
	output logic       irq_raise,
	output logic [7:0] raise_vector,
	output logic       request_pending
);

	item_t   item;
	result_t core_res;
	result_t out_res;
	logic    accept;

	assign item = '{mode: mode, reg_offset: reg_offset, write_value: write_value,
		source_select: source_select, source_level: source_level,
		printer_ready: printer_ready};
	assign accept = in_valid && in_ready;

	vic_core u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.accept (accept),
		.item   (item),
		.result (core_res)
	);

	vic_out_buf u_out_buf (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (accept),
		.push_data (core_res),
		.space     (in_ready),
		.pop_ready (out_ready),
		.pop_valid (out_valid),
		.pop_data  (out_res)
	);

	assign read_value      = out_res.read_value;
	assign irq_cancel      = out_res.irq_cancel;
	assign irq_raise       = out_res.irq_raise;
	assign raise_vector    = out_res.raise_vector;
	assign request_pending = out_res.request_pending;

endmodule
